[rtl/wvps_pkg.sv]
// Package: shared constants, types and helpers of the wake vortex particle shedder.
package wvps_pkg;

   localparam int MaxParticles = 16384;
   localparam int SlotW        = 14;
   localparam int CountW       = 15;

   localparam logic [1:0] CsrFsX = 2'd0;
   localparam logic [1:0] CsrFsY = 2'd1;
   localparam logic [1:0] CsrFsZ = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_NORM,
      ST_SQ,
      ST_SQRT,
      ST_MUL,
      ST_DIV,
      ST_STORE,
      ST_OUT
   } state_type;

   // one particle as it leaves the block
   typedef struct packed {
      logic [31:0]      px;
      logic [31:0]      py;
      logic [31:0]      pz;
      logic [31:0]      vx;
      logic [31:0]      vy;
      logic [31:0]      vz;
      logic [31:0]      strength;
      logic             is_shed;
      logic [SlotW-1:0] slot;
      logic             store_full;
      logic             last;
   } particle_type;

   function automatic logic [31:0] sat32(input logic signed [32:0] v);
      logic [31:0] r;
      if (v > 33'sd2147483647)       r = 32'h7FFF_FFFF;
      else if (v < -33'sd2147483648) r = 32'h8000_0000;
      else                           r = v[31:0];
      return r;
   endfunction

endpackage

[rtl/wvps_divider.sv]
// Radix-2 restoring divider: 63-bit dividend by 32-bit divisor, one quotient bit a cycle.
module wvps_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [62:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [62:0] quotient
);
   import wvps_pkg::*;

   logic [62:0] quot_ff, quot_in;
   logic [32:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[31:0], quot_ff[62]};
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         cnt_in  = 6'd62;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in  = trial - {1'b0, divisor};
            quot_in = {quot_ff[61:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[61:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

[rtl/wake_vortex_particle_shedder_unit.sv]
// Top level: lifting-line wake shedder, one trail and optionally one shed particle per word.
// Each particle passes setup, a normalising shift, three squares, the root steps, then a
// multiply and a divide per component, and a store; the shed word follows the trail word.
// A zero-length direction skips the divides.
// A new input word is accepted only after the last particle of the previous one is stored; ready
// only in idle, as the shared 63-bit divider and the bit-serial square root serve one particle.
// Reset (synchronous, active high) clears free-stream registers, slot counter and control.
module wake_vortex_particle_shedder_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: edge_x, edge_y, edge_z, next_edge_x, next_edge_y, next_edge_z,
   //        circulation, next_circulation, previous_circulation (288 bits)
   input  logic [287:0] req_tdata,
   // tuser: first_in_line, last_in_line
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: particle_x, particle_y, particle_z, vorticity_x, vorticity_y,
   //        vorticity_z, strength, slot, store_full, padded to 240 bits
   output logic [239:0] rsp_tdata,
   // tuser: is_shed
   output logic         rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import wvps_pkg::*;

   // configuration
   logic [31:0] fs_ff [3];
   logic [1:0]  csr_idx;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fs_ff[0] <= '0;
         fs_ff[1] <= '0;
         fs_ff[2] <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_idx)
            CsrFsX:  fs_ff[0] <= csr_pwdata;
            CsrFsY:  fs_ff[1] <= csr_pwdata;
            CsrFsZ:  fs_ff[2] <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CsrFsX:  csr_prdata = fs_ff[0];
         CsrFsY:  csr_prdata = fs_ff[1];
         CsrFsZ:  csr_prdata = fs_ff[2];
         default: csr_prdata = '0;
      endcase
   end

   // captured input word
   logic [31:0] e_ff [3];
   logic [31:0] ne_ff [3];
   logic [31:0] circ_ff, ncirc_ff, pcirc_ff;
   logic        first_ff, lastst_ff;

   // per-particle working set
   state_type   state_ff, state_in;
   logic        shed_ff, shed_in;          // working on the shed particle
   logic [32:0] mag_ff [3];                // component magnitudes
   logic        neg_ff [3];
   logic [31:0] str_ff, str_in;            // saturated strength
   logic [63:0] sum_ff;                    // sum of squares / sqrt remainder source
   logic [31:0] root_ff;
   logic [33:0] srem_ff;
   logic [5:0]  cnt_ff;
   logic [1:0]  k_ff;
   logic [31:0] vort_ff [3];
   logic [CountW-1:0] next_slot_ff;
   particle_type out_ff;
   logic        out_valid_ff;

   logic        div_start, div_done;
   logic [62:0] div_q;
   logic [62:0] mul_prod;

   wvps_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mul_prod),
      .divisor  (root_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign req_tready = (state_ff == ST_IDLE);
   wire req_acc = req_tvalid && req_tready;
   wire rsp_acc = rsp_tvalid && rsp_tready;

   // direction and strength of the particle about to be worked
   logic signed [32:0] dir_s [3];
   logic signed [32:0] str_raw;
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (shed_ff) dir_s[k] = $signed({e_ff[k][31], e_ff[k]}) -
                                 $signed({ne_ff[k][31], ne_ff[k]});
         else         dir_s[k] = $signed({fs_ff[k][31], fs_ff[k]});
      end
      if (shed_ff)        str_raw = $signed({circ_ff[31], circ_ff}) -
                                    $signed({pcirc_ff[31], pcirc_ff});
      else if (first_ff)  str_raw = -$signed({circ_ff[31], circ_ff});
      else if (lastst_ff) str_raw = $signed({circ_ff[31], circ_ff});
      else                str_raw = $signed({circ_ff[31], circ_ff}) -
                                    $signed({ncirc_ff[31], ncirc_ff});
      str_in = sat32(str_raw);
   end

   // square-root step: two radicand bits a cycle; remainder never exceeds 2 x root
   logic [35:0] sq_cur;
   logic [36:0] sq_trial;
   assign sq_cur   = {srem_ff, sum_ff[63:62]};
   assign sq_trial = {1'b0, sq_cur} - {3'b000, root_ff, 2'b01};

   // shared multiplier: one component magnitude times strength magnitude
   logic [31:0] amag;
   logic [30:0] mmag;
   assign amag = str_ff[31] ? (~str_ff + 32'd1) : str_ff;
   always_comb begin
      case (k_ff)
         2'd0:    mmag = mag_ff[0][30:0];
         2'd1:    mmag = mag_ff[1][30:0];
         default: mmag = mag_ff[2][30:0];
      endcase
   end
   assign mul_prod = {32'd0, mmag} * {31'd0, amag};

   // square of the selected magnitude (sum phase)
   logic [61:0] mmag_sq;
   assign mmag_sq = 62'(mmag) * 62'(mmag);

   // signed, saturated vorticity from the quotient
   logic [31:0] vsigned;
   logic [31:0] qsat;
   logic        vneg;
   always_comb begin
      qsat = (div_q > 63'h8000_0000) ? 32'h8000_0000 : div_q[31:0];
      case (k_ff)
         2'd0:    vneg = neg_ff[0] != str_ff[31];
         2'd1:    vneg = neg_ff[1] != str_ff[31];
         default: vneg = neg_ff[2] != str_ff[31];
      endcase
      if (vneg)                      vsigned = ~qsat + 32'd1;
      else if (qsat[31])             vsigned = 32'h7FFF_FFFF;
      else                           vsigned = qsat;
   end

   // midpoint, floor((a + b) / 2)
   logic [31:0] midp [3];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic signed [32:0] s;
         s = $signed({e_ff[k][31], e_ff[k]}) + $signed({ne_ff[k][31], ne_ff[k]});
         midp[k] = s[32:1];
      end
   end

   // next-state logic
   always_comb begin
      state_in = state_ff;
      shed_in  = shed_ff;
      case (state_ff)
         ST_IDLE:  if (req_acc) begin
            state_in = ST_SETUP;
            shed_in  = 1'b0;
         end
         ST_SETUP: state_in = ST_NORM;
         ST_NORM:  if (!mag_ff[0][31] && !mag_ff[1][31] && !mag_ff[2][31] &&
                       !mag_ff[0][32] && !mag_ff[1][32] && !mag_ff[2][32])
                      state_in = ST_SQ;
         ST_SQ:    if (k_ff == 2'd2) state_in = ST_SQRT;
         ST_SQRT:  if (cnt_ff == '0) state_in = ST_MUL;
         ST_MUL:   state_in = (root_ff == '0) ? ST_STORE : ST_DIV;
         ST_DIV:   if (div_done) state_in = (k_ff == 2'd2) ? ST_STORE : ST_MUL;
         ST_STORE: if (!out_valid_ff || rsp_acc) state_in = ST_OUT;
         ST_OUT:   if (shed_ff || lastst_ff || first_ff && lastst_ff) state_in = ST_IDLE;
                   else begin
                      state_in = ST_SETUP;
                      shed_in  = 1'b1;
                   end
         default:  state_in = ST_IDLE;
      endcase
   end

   // divider start, state and output-side control
   assign div_start = (state_ff == ST_MUL) && (root_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         shed_ff      <= 1'b0;
         next_slot_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         shed_ff  <= shed_in;
         if (state_ff == ST_STORE && (!out_valid_ff || rsp_acc)) begin
            out_valid_ff <= 1'b1;
            if (next_slot_ff < CountW'(MaxParticles)) next_slot_ff <= next_slot_ff + 1'b1;
         end else if (rsp_acc) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (req_acc) begin
         for (int k = 0; k < 3; k++) begin
            e_ff[k]  <= req_tdata[32*k +: 32];
            ne_ff[k] <= req_tdata[96 + 32*k +: 32];
         end
         circ_ff   <= req_tdata[192 +: 32];
         ncirc_ff  <= req_tdata[224 +: 32];
         pcirc_ff  <= req_tdata[256 +: 32];
         first_ff  <= req_tuser[0];
         lastst_ff <= req_tuser[1];
      end
      case (state_ff)
         ST_SETUP: begin
            str_ff <= str_in;
            for (int k = 0; k < 3; k++) begin
               neg_ff[k] <= dir_s[k][32];
               mag_ff[k] <= dir_s[k][32] ? 33'(-dir_s[k]) : 33'(dir_s[k]);
               vort_ff[k] <= '0;
            end
            k_ff   <= '0;
            sum_ff <= '0;
         end
         ST_NORM: if (mag_ff[0][32:31] != 0 || mag_ff[1][32:31] != 0 ||
                      mag_ff[2][32:31] != 0) begin
            for (int k = 0; k < 3; k++) mag_ff[k] <= mag_ff[k] >> 1;
         end
         ST_SQ: begin
            sum_ff  <= sum_ff + 64'(mmag_sq);
            k_ff    <= k_ff + 2'd1;
            root_ff <= '0;
            srem_ff <= '0;
            cnt_ff  <= 6'd31;
         end
         ST_SQRT: begin
            if (!sq_trial[36]) begin
               srem_ff <= sq_trial[33:0];
               root_ff <= {root_ff[30:0], 1'b1};
            end else begin
               srem_ff <= sq_cur[33:0];
               root_ff <= {root_ff[30:0], 1'b0};
            end
            sum_ff <= {sum_ff[61:0], 2'b00};
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == '0) k_ff <= '0;
         end
         ST_DIV: if (div_done) begin
            vort_ff[k_ff] <= vsigned;
            k_ff <= k_ff + 2'd1;
         end
         ST_STORE: if (!out_valid_ff || rsp_acc) begin
            out_ff.px         <= shed_ff ? midp[0] : e_ff[0];
            out_ff.py         <= shed_ff ? midp[1] : e_ff[1];
            out_ff.pz         <= shed_ff ? midp[2] : e_ff[2];
            out_ff.vx         <= vort_ff[0];
            out_ff.vy         <= vort_ff[1];
            out_ff.vz         <= vort_ff[2];
            out_ff.strength   <= str_ff;
            out_ff.is_shed    <= shed_ff;
            out_ff.slot       <= (next_slot_ff < CountW'(MaxParticles)) ?
                                 next_slot_ff[SlotW-1:0] : SlotW'(MaxParticles - 1);
            out_ff.store_full <= !(next_slot_ff < CountW'(MaxParticles));
            out_ff.last       <= shed_ff || lastst_ff;
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_ff.store_full, out_ff.slot, out_ff.strength,
                        out_ff.vz, out_ff.vy, out_ff.vx, out_ff.pz, out_ff.py, out_ff.px};
   assign rsp_tuser  = out_ff.is_shed;
   assign rsp_tlast  = out_ff.last;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !out_valid_ff || state_ff == ST_IDLE)
      else $error("ready outside idle");
   a_slot_sat: assert property (@(posedge clock) disable iff (reset)
      next_slot_ff <= CountW'(MaxParticles))
      else $error("slot count beyond store");
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready && state_ff != ST_STORE) |=> $stable(rsp_tdata))
      else $error("result overwritten while stalled");

endmodule
